FILE: hw/rtl/uart_line_command_decoder_defines.svh
// Assertion macros shared by the line command decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UART_LINE_COMMAND_DECODER_DEFINES_SVH
`define UART_LINE_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lcd_pkg.sv
// Package for the line command decoder: keyword tables, codes and cell types.
// No dependencies; used by lcd_kw_cell, lcd_num_scan and the top level.
package lcd_pkg;

  localparam int KW_COUNT       = 13;
  localparam int WIRELESS_COUNT = 8;
  localparam int ARG_OFFSET     = 9;

  localparam logic [3:0] CODE_NONE     = 4'd0;
  localparam logic [3:0] CODE_INTERVAL = 4'd9;

  localparam logic KIND_LINE     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  localparam logic SET_CONSOLE  = 1'b0;
  localparam logic SET_WIRELESS = 1'b1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Keyword text, right aligned: the last character sits in the low byte.
  localparam logic [127:0] CON_TXT [KW_COUNT] = '{
    128'({"led_", "all_on"}), 128'({"led_", "all_off"}), 128'({"led_", "on_up"}),
    128'({"led_", "on_down"}), 128'({"led_", "keepon_up"}), 128'({"led_", "keepon_down"}),
    128'({"led_", "flower_on"}), 128'({"led_", "flower_off"}), 128'("dht11time"),
    128'({"dht11", "_on"}), 128'({"dht11", "_off"}), 128'("ultra_on"), 128'("ultra_off")
  };
  localparam logic [3:0] CON_LEN [KW_COUNT] = '{
    4'd10, 4'd11, 4'd9, 4'd11, 4'd13, 4'd15, 4'd13, 4'd14, 4'd9, 4'd8, 4'd9, 4'd8, 4'd9
  };
  localparam logic [127:0] WL_TXT [WIRELESS_COUNT] = '{
    128'("ledallon"), 128'("ledalloff"), 128'({"led_", "on_up"}), 128'({"led_", "on_down"}),
    128'({"led_", "keepon_up"}), 128'({"led_", "keepon_down"}), 128'({"led_", "flower_on"}),
    128'({"led_", "flower_off"})
  };
  localparam logic [3:0] WL_LEN [WIRELESS_COUNT] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd13, 4'd14
  };

  // Per-cell control, broadcast from the top level to every cell.
  typedef struct packed {
    logic step;       // an ordinary byte is stored in the line
    logic clear;      // line end or overflow: restart the line
    logic kw_set;     // keyword list selected now
  } lcd_ctl_t;

  function automatic logic [3:0] kw_len(input logic kw_set, input logic [3:0] k);
    logic [3:0] len;
    if (kw_set == SET_WIRELESS && k < 4'(WIRELESS_COUNT)) begin
      len = WL_LEN[k[2:0]];
    end else begin
      len = CON_LEN[k];
    end
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic kw_set, input logic [3:0] k,
                                         input logic [3:0] pos);
    logic [127:0] txt;
    logic [3:0]   len;
    logic [6:0]   sh;
    logic [127:0] shifted;
    if (kw_set == SET_WIRELESS && k < 4'(WIRELESS_COUNT)) begin
      txt = WL_TXT[k[2:0]];
      len = WL_LEN[k[2:0]];
    end else begin
      txt = CON_TXT[k];
      len = CON_LEN[k];
    end
    sh      = {4'(len - 4'd1 - pos), 3'b000};
    shifted = txt >> sh;
    return shifted[7:0];
  endfunction

endpackage

FILE: hw/rtl/lcd_kw_cell.sv
// One keyword cell: keeps the alive flag of one keyword and takes part in the
// first-match chain at line end. Depends on lcd_pkg.
module lcd_kw_cell #(
  parameter int K     = 0,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  lcd_pkg::lcd_ctl_t ctl,
  input  logic [7:0]       rx_byte,
  input  logic [CNT_W-1:0] count,
  input  logic [3:0]       code_in,
  output logic [3:0]       code_out
);
  import lcd_pkg::*;

  logic       alive;
  logic       alive_next;
  logic       in_list;
  logic [3:0] len;
  logic [7:0] expect_char;
  logic       hit;

  assign in_list     = (ctl.kw_set == SET_CONSOLE) || (K < WIRELESS_COUNT);
  assign len         = kw_len(ctl.kw_set, 4'(K));
  assign expect_char = kw_char(ctl.kw_set, 4'(K), count[3:0]);

  always_comb begin
    alive_next = alive;
    if (ctl.clear) begin
      alive_next = 1'b1;
    end else if (ctl.step && in_list && count < CNT_W'(len) && expect_char != rx_byte) begin
      alive_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b1;
    end else begin
      alive <= alive_next;
    end
  end

  // An earlier cell that already matched wins; otherwise this one offers its code.
  assign hit      = alive && in_list && count >= CNT_W'(len);
  assign code_out = (code_in != CODE_NONE) ? code_in : (hit ? 4'(K + 1) : CODE_NONE);

endmodule

FILE: hw/rtl/lcd_num_scan.sv
// Decimal value scanner: skips blanks, takes one sign, accumulates digits
// with saturation at 2^31. Depends on lcd_pkg.
module lcd_num_scan (
  input  logic              clk,
  input  logic              rst,
  input  lcd_pkg::lcd_ctl_t ctl,
  input  logic              scan_en,
  input  logic [7:0]        rx_byte,
  output logic [31:0]       value
);
  import lcd_pkg::*;

  localparam logic [1:0] PH_BLANK  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  logic [31:0] acc, acc_next;
  logic [1:0]  phase, phase_next;
  logic        neg, neg_next;
  logic        is_digit, is_blank, is_sign;
  logic [35:0] prod;

  assign is_digit = rx_byte inside {[8'h30:8'h39]};
  assign is_blank = rx_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C};
  assign is_sign  = rx_byte inside {8'h2B, 8'h2D};
  assign prod     = {acc, 3'b000} + {3'b000, acc, 1'b0} + 36'(rx_byte - 8'h30);

  always_comb begin
    acc_next   = acc;
    phase_next = phase;
    neg_next   = neg;
    if (ctl.clear) begin
      acc_next   = '0;
      phase_next = PH_BLANK;
      neg_next   = 1'b0;
    end else if (ctl.step && scan_en) begin
      case (phase)
        PH_BLANK: begin
          if (is_sign) begin
            neg_next   = (rx_byte == 8'h2D);
            phase_next = PH_DIGITS;
          end else if (is_digit) begin
            phase_next = PH_DIGITS;
            acc_next   = (prod > MAG_LIMIT) ? MAG_LIMIT[31:0] : prod[31:0];
          end else if (!is_blank) begin
            phase_next = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_next = (prod > MAG_LIMIT) ? MAG_LIMIT[31:0] : prod[31:0];
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      phase <= PH_BLANK;
      neg   <= 1'b0;
    end else begin
      acc   <= acc_next;
      phase <= phase_next;
      neg   <= neg_next;
    end
  end

  always_comb begin
    if (neg) begin
      value = 32'd0 - acc;
    end else begin
      value = acc[31] ? 32'h7FFF_FFFF : acc;
    end
  end

endmodule

FILE: hw/rtl/uart_line_command_decoder.sv
// Line command decoder: top level with the keyword cell row, value scanner
// and output register. Depends on lcd_pkg, lcd_kw_cell, lcd_num_scan.
//
// The block takes one received byte per transaction and frames lines ended by
// LF or CR. A terminator produces one result transaction carrying the code of
// the first keyword (in list order) that prefixes the line, the line length
// and, for the interval keyword of the console list, a saturated signed
// decimal value read from byte offset 9 onward. When LINE_MAX bytes are
// stored, the next byte is dropped and an overflow result is given instead.
// Ordinary bytes produce no result. A new byte is accepted every cycle unless
// input stalls; a result appears in the output register in the cycle after its byte,
// and input stalls only while that register holds a result the sink has not taken.
// Each keyword has its own cell that clears its alive flag on the first
// mismatching byte; at line end the cells pass the winning code down the row.
module uart_line_command_decoder #(
  parameter int LINE_MAX = 40
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: keyword_set (0 = console list, 1 = wireless list).
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Byte input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [3:0] command_code, [35:4] argument, [41:36] line_length
  output logic        m_tuser    // [0] kind
);
  import lcd_pkg::*;
  `include "uart_line_command_decoder_defines.svh"

  localparam int CNT_W = $clog2(LINE_MAX + 1);

  logic             keyword_set;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             overflow;
  logic             terminator;
  lcd_ctl_t         ctl;
  logic [3:0]       code_chain [KW_COUNT+1];
  logic [31:0]      num_value;
  logic [31:0]      argument;
  logic             scan_en;

  // Configuration register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_set <= SET_CONSOLE;
    end else if (cfg_wr_en) begin
      keyword_set <= cfg_wr_data;
    end
  end

  // The output register frees up in the same cycle the sink takes its result.
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign overflow   = (count == CNT_W'(LINE_MAX));
  assign terminator = (s_tdata == CHAR_LF) || (s_tdata == CHAR_CR);

  assign ctl.step   = accept && !overflow && !terminator;
  assign ctl.clear  = accept && (overflow || terminator);
  assign ctl.kw_set = keyword_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.step) begin
      count <= count + CNT_W'(1);
    end
  end

  // Keyword cell row; code_chain carries the first match toward the end.
  assign code_chain[0] = CODE_NONE;
  for (genvar k = 0; k < KW_COUNT; k++) begin : g_cell
    lcd_kw_cell #(
      .K     (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .rx_byte  (s_tdata),
      .count    (count),
      .code_in  (code_chain[k]),
      .code_out (code_chain[k+1])
    );
  end

  assign scan_en = (count >= CNT_W'(ARG_OFFSET));

  lcd_num_scan u_num (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .scan_en (scan_en),
    .rx_byte (s_tdata),
    .value   (num_value)
  );

  assign argument = (keyword_set == SET_CONSOLE && code_chain[KW_COUNT] == CODE_INTERVAL) ?
                    num_value : 32'd0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      if (overflow) begin
        m_tuser <= KIND_OVERFLOW;
        m_tdata <= {6'd0, 6'(LINE_MAX), 32'd0, CODE_NONE};
      end else begin
        m_tuser <= KIND_LINE;
        m_tdata <= {6'd0, 6'(count), argument, code_chain[KW_COUNT]};
      end
    end
  end

  `LCD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(LINE_MAX),
                  "line byte count exceeds LINE_MAX")
  `LCD_ASSERT_NEXT(a_result_loaded, clk, rst, ctl.clear, m_tvalid,
                   "line end or overflow did not load a result")
  `LCD_ASSERT_NEXT(a_count_step, clk, rst, ctl.step,
                   count == $past(count) + CNT_W'(1), "stored byte did not advance the count")
  `LCD_ASSERT_NOW(a_overflow_zero, clk, rst, m_tvalid && m_tuser == KIND_OVERFLOW,
                  m_tdata[35:0] == 36'd0, "overflow result carries a code or value")

endmodule

FILE: dv/uart_line_command_decoder_test.sv
// Self-checking testbench for uart_line_command_decoder: a directed table of lines,
// then random lines in phases under both keyword lists. Depends on lcd_pkg and the RTL.
`timescale 1ns / 1ps

module uart_line_command_decoder_test;
  import lcd_pkg::*;

  localparam int LINE_MAX    = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SHOW_LIMIT  = 10;
  localparam int PHASE_BYTES = 220;
  localparam int PHASES      = 6;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_FILL = "#";

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ALL_ON, CMD_ALL_OFF, CMD_ON_UP, CMD_ON_DOWN,
    CMD_KEEPON_UP, CMD_KEEPON_DOWN, CMD_FLOWER_ON, CMD_FLOWER_OFF, CMD_DHT_TIME,
    CMD_DHT_ON, CMD_DHT_OFF, CMD_ULTRA_ON, CMD_ULTRA_OFF
  } cmd_code_t;

  // Number scanner state: skipping blanks, taking digits, finished.
  typedef enum logic [1:0] {NUM_SKIP, NUM_DIGITS, NUM_DONE} num_state_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  code;
    logic [31:0] arg;
    logic [5:0]  len;
  } line_result_t;

  // One directed line: keyword list to select, an optional keyword of that list that
  // starts the line, the rest of the text, optional filler bytes, an optional position
  // where a zero byte replaces the text, the final byte and a typed expectation.
  typedef struct {
    logic         set;
    int           kw;
    string        text;
    int           fill;
    int           nul_at;
    bit           ends;
    logic [7:0]   term;
    bit           typed;
    line_result_t res;
  } line_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;

  string console_kw[KW_COUNT];
  string wireless_kw[WIRELESS_COUNT];
  logic [7:0] blanks[4] = '{" ", CH_TAB, CH_VT, CH_FF};

  line_row_t directed_lines[27] = '{
    '{SET_CONSOLE, -1, "", 0, -1, 1, CHAR_LF, 1, '{KIND_LINE, CMD_NONE, 32'd0, 6'd0}},
    '{SET_CONSOLE, 0, "", 0, -1, 1, CHAR_CR, 1,
      '{KIND_LINE, CMD_ALL_ON, 32'd0, 6'd10}},
    '{SET_CONSOLE, 1, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_ALL_OFF, 32'd0, 6'd11}},
    '{SET_CONSOLE, 2, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_ON_UP, 32'd0, 6'd9}},
    '{SET_CONSOLE, 3, "", 0, -1, 1, CHAR_CR, 1,
      '{KIND_LINE, CMD_ON_DOWN, 32'd0, 6'd11}},
    '{SET_CONSOLE, 4, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_KEEPON_UP, 32'd0, 6'd13}},
    '{SET_CONSOLE, 5, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_KEEPON_DOWN, 32'd0, 6'd15}},
    '{SET_CONSOLE, 6, "", 0, -1, 1, CHAR_CR, 1,
      '{KIND_LINE, CMD_FLOWER_ON, 32'd0, 6'd13}},
    '{SET_CONSOLE, 7, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_FLOWER_OFF, 32'd0, 6'd14}},
    '{SET_CONSOLE, -1, "dht11time 2147483647", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_DHT_TIME, 32'h7FFF_FFFF, 6'd20}},
    '{SET_CONSOLE, -1, "dht11time-2147483648", 0, -1, 1, CHAR_CR, 1,
      '{KIND_LINE, CMD_DHT_TIME, 32'h8000_0000, 6'd20}},
    '{SET_CONSOLE, -1, "dht11time 99999999999", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_DHT_TIME, 32'h7FFF_FFFF, 6'd21}},
    '{SET_CONSOLE, -1, "dht11time \t+42\377x", 0, -1, 1, CHAR_LF, 0, '0},
    '{SET_CONSOLE, 9, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_DHT_ON, 32'd0, 6'd8}},
    '{SET_CONSOLE, 10, "", 0, -1, 1, CHAR_CR, 1,
      '{KIND_LINE, CMD_DHT_OFF, 32'd0, 6'd9}},
    '{SET_CONSOLE, -1, "ultra_on", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_ULTRA_ON, 32'd0, 6'd8}},
    '{SET_CONSOLE, -1, "ultra_off", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_ULTRA_OFF, 32'd0, 6'd9}},
    '{SET_CONSOLE, -1, "ultra_on_extra", 0, -1, 1, CHAR_LF, 0, '0},
    '{SET_CONSOLE, 0, "", 0, 3, 1, CHAR_LF, 0, '0},
    '{SET_CONSOLE, 0, "", 29, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_ALL_ON, 32'd0, 6'd39}},
    '{SET_CONSOLE, -1, "", 40, -1, 1, CHAR_LF, 1,
      '{KIND_OVERFLOW, CMD_NONE, 32'd0, 6'd40}},
    '{SET_CONSOLE, -1, "", 40, -1, 1, "x", 1, '{KIND_OVERFLOW, CMD_NONE, 32'd0, 6'd40}},
    '{SET_WIRELESS, -1, "ledallon", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_ALL_ON, 32'd0, 6'd8}},
    '{SET_WIRELESS, -1, "ledalloff", 0, -1, 1, CHAR_CR, 1,
      '{KIND_LINE, CMD_ALL_OFF, 32'd0, 6'd9}},
    '{SET_WIRELESS, 7, "", 0, -1, 1, CHAR_LF, 1,
      '{KIND_LINE, CMD_FLOWER_OFF, 32'd0, 6'd14}},
    // The list changes in the middle of this line: the first bytes are compared
    // against the wireless list, the rest and the final match against the console list.
    '{SET_WIRELESS, -1, "dht11", 0, -1, 0, CHAR_LF, 0, '0},
    '{SET_CONSOLE, -1, "time 7", 0, -1, 1, CHAR_LF, 0, '0}
  };

  // Predictor state, a copy of what the block keeps per line.
  int unsigned  line_fill;
  logic [12:0]  kw_live;
  logic [31:0]  num_mag;
  num_state_t   num_state;
  logic         num_neg;
  logic         kw_set_now;

  line_result_t pending_results[$];
  logic [7:0]   line_buf[$];
  int           errors;
  int           cycle_count;
  int           hold_left;
  bit           gaps_on;
  bit           stall_on;

  uart_line_command_decoder #(.LINE_MAX(LINE_MAX)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic string join_text(input string head, input string tail);
    return {head, tail};
  endfunction

  // Keyword lists in code order.
  function automatic void init_words();
    console_kw = '{
      join_text("led_", "all_on"), join_text("led_", "all_off"), join_text("led_", "on_up"),
      join_text("led_", "on_down"), join_text("led_", "keepon_up"),
      join_text("led_", "keepon_down"), join_text("led_", "flower_on"),
      join_text("led_", "flower_off"), "dht11time", join_text("dht11", "_on"),
      join_text("dht11", "_off"), "ultra_on", "ultra_off"
    };
    wireless_kw = '{
      "ledallon", "ledalloff", join_text("led_", "on_up"), join_text("led_", "on_down"),
      join_text("led_", "keepon_up"), join_text("led_", "keepon_down"),
      join_text("led_", "flower_on"), join_text("led_", "flower_off")
    };
  endfunction

  function automatic void restart_line();
    line_fill = 0;
    kw_live   = '1;
    num_mag   = '0;
    num_state = NUM_SKIP;
    num_neg   = 1'b0;
  endfunction

  function automatic string kw_text(input int k);
    return (kw_set_now == SET_WIRELESS) ? wireless_kw[k] : console_kw[k];
  endfunction

  // atoi-style scan with the magnitude held at 2^31.
  function automatic void scan_number(input logic [7:0] b);
    logic [63:0] v;
    bit          is_digit;
    is_digit = (b >= "0") && (b <= "9");
    if (num_state == NUM_SKIP) begin
      if (b == " " || b == CH_TAB || b == CH_VT || b == CH_FF) return;
      if (b == "+" || b == "-") begin
        num_neg   = (b == "-");
        num_state = NUM_DIGITS;
        return;
      end
      num_state = is_digit ? NUM_DIGITS : NUM_DONE;
    end
    if (num_state == NUM_DIGITS) begin
      if (is_digit) begin
        v = 64'(num_mag) * 64'd10 + 64'(b - "0");
        num_mag = (v > 64'h8000_0000) ? 32'h8000_0000 : v[31:0];
      end else begin
        num_state = NUM_DONE;
      end
    end
  endfunction

  // Advances the predicted state by one accepted byte; returns 1 when a result is due.
  function automatic bit decode_byte(input logic [7:0] b, output line_result_t r);
    int    n;
    bit    hit;
    string kw;
    n = (kw_set_now == SET_WIRELESS) ? WIRELESS_COUNT : KW_COUNT;
    r = '0;
    if (line_fill >= LINE_MAX) begin
      r.kind = KIND_OVERFLOW;
      r.code = CODE_NONE;
      r.len  = 6'(LINE_MAX);
      restart_line();
      return 1'b1;
    end
    if (b == CHAR_LF || b == CHAR_CR) begin
      hit    = 1'b0;
      r.kind = KIND_LINE;
      r.code = CODE_NONE;
      for (int k = 0; k < n; k++) begin
        kw = kw_text(k);
        if (!hit && kw_live[k] && line_fill >= kw.len()) begin
          r.code = 4'(k + 1);
          hit    = 1'b1;
        end
      end
      if (kw_set_now == SET_CONSOLE && r.code == CODE_INTERVAL) begin
        if (num_neg) r.arg = 32'd0 - num_mag;
        else r.arg = (num_mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_mag;
      end
      r.len = 6'(line_fill);
      restart_line();
      return 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      kw = kw_text(k);
      if (line_fill < kw.len() && kw[line_fill] != b) kw_live[k] = 1'b0;
    end
    if (line_fill >= ARG_OFFSET) scan_number(b);
    line_fill++;
    return 1'b0;
  endfunction

  // A value field for the interval keyword: blanks, a sign, digits and a tail.
  function automatic void add_number();
    int digits;
    repeat ($urandom_range(0, 2)) line_buf.push_back(blanks[$urandom_range(0, 3)]);
    case ($urandom_range(0, 2))
      1: line_buf.push_back("+");
      2: line_buf.push_back("-");
      default: ;
    endcase
    digits = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (digits) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Mostly keyword lines with random content and damage; the rest is raw noise,
  // some of it long enough to overflow. An open line has no terminator and may be cut.
  function automatic void build_line(input bit open_line);
    string kw;
    int    pick;
    int    cut;
    pick = $urandom_range(0, 99);
    line_buf.delete();
    if (pick < 75) begin
      if ($urandom_range(0, 2) == 0) kw = wireless_kw[$urandom_range(0, WIRELESS_COUNT - 1)];
      else kw = console_kw[$urandom_range(0, KW_COUNT - 1)];
      cut = kw.len();
      if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, kw.len());
      for (int i = 0; i < cut; i++) line_buf.push_back(kw[i]);
      if (cut > 0 && $urandom_range(0, 5) == 0)
        line_buf[$urandom_range(0, cut - 1)] = 8'($urandom_range(0, 255));
      if (kw == "dht11time" || $urandom_range(0, 4) == 0) add_number();
      repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(32, 126)));
    end else begin
      cut = (pick < 90) ? $urandom_range(0, 20) : $urandom_range(36, 45);
      repeat (cut) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (open_line) begin
      while (line_buf.size() > 0 && $urandom_range(0, 1) == 0) void'(line_buf.pop_back());
    end else begin
      line_buf.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
    end
  endfunction

  // One transaction on the byte input. A typed expectation, when given, replaces
  // the predicted one for the result this byte causes.
  task automatic send_byte(input logic [7:0] b, input bit typed, input line_result_t want);
    line_result_t r;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (decode_byte(b, r)) pending_results.push_back(typed ? want : r);
  endtask

  // The register is written only once every expected result is out and the
  // block has had time to finish any byte that gives no result.
  task automatic set_keywords(input logic v);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    kw_set_now = v;
  endtask

  // Result sink with random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (stall_on && $urandom_range(0, 9) == 0) begin
      m_tready  <= 1'b0;
      hold_left = $urandom_range(0, 18);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[41:36]};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("unexpected result: kind %0d code %0d arg %0d len %0d",
                   got.kind, got.code, $signed(got.arg), got.len);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.code !== want.code ||
            got.arg !== want.arg || got.len !== want.len) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("mismatch: expected kind %0d code %0d arg %0d len %0d, got kind %0d code %0d arg %0d len %0d",
                     want.kind, want.code, $signed(want.arg), want.len,
                     got.kind, got.code, $signed(got.arg), got.len);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int    sent;
    logic  start_set;
    string row_text;
    init_words();
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    errors      = 0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    stall_on    = 1'b1;
    kw_set_now  = SET_CONSOLE;
    restart_line();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_lines[i]) begin
      if (directed_lines[i].set !== kw_set_now) set_keywords(directed_lines[i].set);
      row_text = directed_lines[i].text;
      if (directed_lines[i].kw >= 0) row_text = {kw_text(directed_lines[i].kw), row_text};
      for (int j = 0; j < row_text.len(); j++)
        send_byte((j == directed_lines[i].nul_at) ? CH_NUL : row_text[j], 1'b0, '0);
      repeat (directed_lines[i].fill) send_byte(CH_FILL, 1'b0, '0);
      if (directed_lines[i].ends)
        send_byte(directed_lines[i].term, directed_lines[i].typed, directed_lines[i].res);
    end

    // Random phases, alternating lists; the last phase runs without idling.
    start_set = 1'($urandom_range(0, 1));
    for (int ph = 0; ph < PHASES; ph++) begin
      set_keywords(start_set ^ 1'(ph));
      gaps_on  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      stall_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_line(1'b0);
        foreach (line_buf[j]) send_byte(line_buf[j], 1'b0, '0);
        sent += line_buf.size();
      end
      // Leave a line open so the next register write lands mid-line.
      if ($urandom_range(0, 1) == 0) begin
        build_line(1'b1);
        foreach (line_buf[j]) send_byte(line_buf[j], 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
